// ===== sv/gol_pkg.sv =====
// Shared types, constants and the B3/S23 rule function for the life stencil.
`default_nettype none
package gol_pkg;

  // Default size limits of the block.
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Configuration port widths.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned POS_W      = 10;

  // Smallest usable frame dimension, border included.
  localparam int unsigned MIN_DIM = 3;

  // Register reset values.
  localparam logic [DIM_W-1:0]  ROW_WIDTH_RST    = 11'd1024;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [BAND_W-1:0] FIRST_ROW_RST    = 10'd1;
  localparam logic [BAND_W-1:0] STOP_ROW_RST     = 10'd1023;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROW_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_FIRST_ROW    = 3'd2,
    CFG_STOP_ROW     = 3'd3
  } cfg_reg_t;

  // Position and band flags of the centre that an incoming cell completes.
  typedef struct packed {
    logic             produce;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } scan_info_t;

  // Columns are packed top in bit 2, middle in bit 1, bottom in bit 0.
  function automatic logic [1:0] ones3(input logic [2:0] col);
    ones3 = {1'b0, col[0]} + {1'b0, col[1]} + {1'b0, col[2]};
  endfunction

  function automatic logic life_rule(input logic [2:0] left, input logic [2:0] centre_col,
                                     input logic [2:0] right);
    logic [3:0] n;
    n = {2'b00, ones3(left)} + {2'b00, ones3(right)}
        + {3'b000, centre_col[2]} + {3'b000, centre_col[0]};
    life_rule = (n == 4'd3) || (centre_col[1] && (n == 4'd2));
  endfunction

endpackage
`default_nettype wire

// ===== sv/game_of_life_stencil.sv =====
// Top level of the Game of Life B3/S23 raster stencil.
//
// Cells of a frame enter one per transfer in raster order; the block emits the next
// state of each interior centre cell in the row band [first_row, stop_row) once the
// cell below and to the right of it has arrived, tagged with its row, column and a
// flag on the last cell of the band. One cell is taken per clock cycle unless in_stall
// is raised by a stalled output. A result passes stage one with the registered line
// store read, then the window and rule into the output register. The line store holds
// MAX_WIDTH entries of two bits and needs no clearing after reset; the user must write
// configuration between frames while the block idles; the block does not enforce it.
`default_nettype none
module game_of_life_stencil #(
  parameter int unsigned MAX_WIDTH  = gol_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = gol_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [gol_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [gol_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cell_req,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_next_cell,
  output logic      [gol_pkg::POS_W-1:0]      out_row,
  output logic      [gol_pkg::POS_W-1:0]      out_col,
  output logic                                out_last_of_band
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [gol_pkg::DIM_W-1:0]  row_width_r, frame_height_r;
  logic [gol_pkg::BAND_W-1:0] first_row_r, stop_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= gol_pkg::ROW_WIDTH_RST;
      frame_height_r <= gol_pkg::FRAME_HEIGHT_RST;
      first_row_r    <= gol_pkg::FIRST_ROW_RST;
      stop_row_r     <= gol_pkg::STOP_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        gol_pkg::CFG_ROW_WIDTH:    row_width_r    <= cfg_wdata[gol_pkg::DIM_W-1:0];
        gol_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[gol_pkg::DIM_W-1:0];
        gol_pkg::CFG_FIRST_ROW:    first_row_r    <= cfg_wdata[gol_pkg::BAND_W-1:0];
        gol_pkg::CFG_STOP_ROW:     stop_row_r     <= cfg_wdata[gol_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage one drains into the output register when that register is free.
  logic in_accept, s1_adv;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_cell_r;
  logic [AW-1:0] s1_idx_r;
  gol_pkg::scan_info_t s1_info_r;

  logic [AW-1:0] scan_idx;
  gol_pkg::scan_info_t scan_info;
  logic [1:0] line_rd;
  logic next_cell;

  logic out_valid_r, out_valid_nxt;
  logic out_next_cell_r, out_last_r;
  logic [gol_pkg::POS_W-1:0] out_row_r, out_col_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  gol_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (in_accept),
    .row_width    (row_width_r),
    .frame_height (frame_height_r),
    .first_row    (first_row_r),
    .stop_row     (stop_row_r),
    .idx          (scan_idx),
    .info         (scan_info)
  );

  // Each column entry is read when its cell is accepted and rewritten one stage later;
  // consecutive cells always differ in column, so the two never collide.
  gol_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (scan_idx),
    .rd_data (line_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx_r),
    .wr_data ({line_rd[0], s1_cell_r})
  );

  gol_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_adv),
    .new_col   ({line_rd, s1_cell_r}),
    .next_cell (next_cell)
  );

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = s1_info_r.produce;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell_r <= in_cell_req;
      s1_idx_r  <= scan_idx;
      s1_info_r <= scan_info;
    end
    if (s1_adv) begin
      out_next_cell_r <= next_cell;
      out_last_r      <= s1_info_r.last;
      out_row_r       <= s1_info_r.row;
      out_col_r       <= s1_info_r.col;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_cell    = out_next_cell_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_last_of_band = out_last_r;

endmodule
`default_nettype wire

// ===== sv/gol_line_buf.sv =====
// Two-row line store, one entry per column, with a registered read port.
`default_nettype none
module gol_line_buf #(
  parameter int unsigned MAX_WIDTH = gol_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [1:0]    rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data
);

  // Bit 1 holds the row two above the incoming row, bit 0 the row just above.
  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/gol_scan.sv =====
// Raster position counters and row band decode for each incoming cell.
`default_nettype none
module gol_scan #(
  parameter int unsigned MAX_WIDTH  = gol_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = gol_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [gol_pkg::DIM_W-1:0]   row_width,
  input  wire logic [gol_pkg::DIM_W-1:0]   frame_height,
  input  wire logic [gol_pkg::BAND_W-1:0]  first_row,
  input  wire logic [gol_pkg::BAND_W-1:0]  stop_row,
  output logic      [AW-1:0]               idx,
  output gol_pkg::scan_info_t              info
);

  localparam int unsigned CW0 = (AW + 2 > RW + 2) ? AW + 2 : RW + 2;
  localparam int unsigned CW  = (CW0 > 12) ? CW0 : 12;

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [CW-1:0] w_raw, h_raw, w, h, lo, hi, stop_ext, h_m1;
  logic [CW-1:0] col_ext, c, r_pre, r, c_inc, r_inc, r_m1, c_m1;
  logic          wrap_c;

  always_comb begin
    // Effective limits from the configuration registers.
    w_raw = CW'(row_width);
    h_raw = CW'(frame_height);
    if (w_raw < CW'(gol_pkg::MIN_DIM)) begin
      w = CW'(gol_pkg::MIN_DIM);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = w_raw;
    end
    if (h_raw < CW'(gol_pkg::MIN_DIM)) begin
      h = CW'(gol_pkg::MIN_DIM);
    end else if (h_raw > CW'(MAX_HEIGHT)) begin
      h = CW'(MAX_HEIGHT);
    end else begin
      h = h_raw;
    end
    lo       = (first_row == '0) ? CW'(1) : CW'(first_row);
    stop_ext = CW'(stop_row);
    h_m1     = h - CW'(1);
    hi       = (stop_ext < h_m1) ? stop_ext : h_m1;

    // A counter left beyond a lowered limit wraps before this cell is placed.
    col_ext = CW'(col_r);
    wrap_c  = col_ext >= w;
    c       = wrap_c ? '0 : col_ext;
    r_pre   = wrap_c ? CW'(row_r) + CW'(1) : CW'(row_r);
    r       = (r_pre >= h) ? '0 : r_pre;

    c_inc = c + CW'(1);
    r_inc = r + CW'(1);
    if (c_inc >= w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c_inc[AW-1:0];
      row_nxt = r[RW-1:0];
    end

    r_m1 = r - CW'(1);
    c_m1 = c - CW'(1);
    info.produce = (r >= CW'(2)) && (c >= CW'(2)) && (r_m1 >= lo) && (r_m1 < hi);
    info.last    = (r_m1 == hi - CW'(1)) && (c_m1 == w - CW'(2));
    info.row     = r_m1[gol_pkg::POS_W-1:0];
    info.col     = c_m1[gol_pkg::POS_W-1:0];
    idx          = c[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gol_window.sv =====
// Two-column neighbourhood window and the B3/S23 next-state decision.
`default_nettype none
module gol_window (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [2:0] new_col,
  output logic            next_cell
);

  // Bits 2:0 hold the previous column, bits 5:3 the one before it.
  logic [5:0] win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (en) begin
      win_r <= {win_r[2:0], new_col};
    end
  end

  assign next_cell = gol_pkg::life_rule(win_r[5:3], win_r[2:0], new_col);

endmodule
`default_nettype wire
